// ----- sv/stms_pkg.sv -----
package stms_pkg;

   // field widths
   localparam int COORD_BITS   = 10;
   localparam int DELTA_W      = COORD_BITS + 1;
   localparam int MAG_W        = COORD_BITS;
   localparam int SCALE_W      = 8;
   localparam int SPEED_MAG_W  = SCALE_W;
   localparam int SPEED_W      = SPEED_MAG_W + 1;
   localparam int BIT_IDX_W    = $clog2(SPEED_MAG_W);

   // datapath widths
   localparam int SQ1_W        = 2 * MAG_W;
   localparam int SQ_W         = SQ1_W + 1;
   localparam int NUM_W        = MAG_W + SCALE_W;
   localparam int TGT_W        = 2 * NUM_W;
   localparam int TSQ_W        = 2 * SPEED_MAG_W;
   localparam int PROD_W       = TSQ_W + SQ_W;

   // stream widths
   localparam int IN_RAW_W     = 2 * COORD_BITS;
   localparam int IN_DATA_W    = ((IN_RAW_W + 7) / 8) * 8;
   localparam int OUT_RAW_W    = 2 * DELTA_W + 2 * SPEED_W;
   localparam int OUT_DATA_W   = ((OUT_RAW_W + 7) / 8) * 8;

   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(100);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ,
      ST_SUM,
      ST_TSQ,
      ST_PROD,
      ST_CMP,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                 load;
      logic                 sq;
      logic                 sum;
      logic                 tsq;
      logic                 prod;
      logic                 cmp;
      logic                 out_load;
      logic [BIT_IDX_W-1:0] bit_idx;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ----- sv/stms_ctrl.sv -----
module stms_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tlast,
   output logic                req_tready,
   input  stms_pkg::status_type status,
   output stms_pkg::cmd_type    cmd
);
   import stms_pkg::*;

   state_type            state_ff, state_in;
   logic [BIT_IDX_W-1:0] bit_ff, bit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         bit_ff   <= bit_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      bit_in   = bit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = req_tlast ? ST_OUT : ST_SQ;
            end
         end
         ST_SQ:   state_in = ST_SUM;
         ST_SUM: begin
            state_in = ST_TSQ;
            bit_in   = BIT_IDX_W'(SPEED_MAG_W - 1);
         end
         ST_TSQ:  state_in = ST_PROD;
         ST_PROD: state_in = ST_CMP;
         ST_CMP: begin
            if (bit_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_TSQ;
               bit_in   = bit_ff - BIT_IDX_W'(1);
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd         = '0;
      cmd.bit_idx = bit_ff;
      req_tready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_SQ:   cmd.sq   = 1'b1;
         ST_SUM:  cmd.sum  = 1'b1;
         ST_TSQ:  cmd.tsq  = 1'b1;
         ST_PROD: cmd.prod = 1'b1;
         ST_CMP:  cmd.cmp  = 1'b1;
         ST_OUT:  cmd.out_load = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

// ----- sv/stms_dp.sv -----
module stms_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wen,
   input  logic [stms_pkg::SCALE_W-1:0]         csr_wdata,
   input  logic [stms_pkg::COORD_BITS-1:0]      in_x,
   input  logic [stms_pkg::COORD_BITS-1:0]      in_y,
   input  logic                                 in_lift,
   input  stms_pkg::cmd_type                    cmd,
   output stms_pkg::status_type                 status,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic                                 out_lift,
   output logic signed [stms_pkg::DELTA_W-1:0]  out_dx,
   output logic signed [stms_pkg::DELTA_W-1:0]  out_dy,
   output logic signed [stms_pkg::SPEED_W-1:0]  out_sx,
   output logic signed [stms_pkg::SPEED_W-1:0]  out_sy
);
   import stms_pkg::*;

   logic [SCALE_W-1:0]      scale_ff;
   logic [COORD_BITS-1:0]   last_x_ff, last_y_ff;
   logic                    lift_ff;
   logic [DELTA_W-1:0]      dx_ff, dy_ff, dx_in, dy_in;
   logic [MAG_W-1:0]        ax_ff, ay_ff;
   logic [SQ1_W-1:0]        sqx_ff, sqy_ff;
   logic [NUM_W-1:0]        numx_ff, numy_ff;
   logic [SQ_W-1:0]         q_ff;
   logic [TGT_W-1:0]        tgtx_ff, tgty_ff;
   logic [TSQ_W-1:0]        tsqx_ff, tsqy_ff;
   logic [PROD_W-1:0]       prodx_ff, prody_ff;
   logic [SPEED_MAG_W-1:0]  kx_ff, ky_ff, tx, ty, bit_mask;
   logic [SPEED_MAG_W-1:0]  kx_out, ky_out;
   logic                    rsp_valid_ff;
   logic                    out_lift_ff;
   logic [DELTA_W-1:0]      out_dx_ff, out_dy_ff;
   logic [SPEED_W-1:0]      out_sx_ff, out_sy_ff;
   logic                    zero_len;

   assign dx_in    = {1'b0, in_x} - {1'b0, last_x_ff};
   assign dy_in    = {1'b0, in_y} - {1'b0, last_y_ff};
   assign bit_mask = SPEED_MAG_W'(1) << cmd.bit_idx;
   assign tx       = kx_ff | bit_mask;
   assign ty       = ky_ff | bit_mask;
   assign zero_len = (q_ff == '0);
   assign kx_out   = zero_len ? '0 : kx_ff;
   assign ky_out   = zero_len ? '0 : ky_ff;

   assign status.out_free = !rsp_valid_ff || rsp_tready;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= SCALE_RESET;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            scale_ff <= csr_wdata;
         end
         if (cmd.load && !in_lift) begin
            last_x_ff <= in_x;
            last_y_ff <= in_y;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         lift_ff <= in_lift;
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         ax_ff   <= dx_in[DELTA_W-1] ? MAG_W'(-dx_in) : MAG_W'(dx_in);
         ay_ff   <= dy_in[DELTA_W-1] ? MAG_W'(-dy_in) : MAG_W'(dy_in);
         kx_ff   <= '0;
         ky_ff   <= '0;
      end
      if (cmd.sq) begin
         sqx_ff  <= SQ1_W'(ax_ff) * SQ1_W'(ax_ff);
         sqy_ff  <= SQ1_W'(ay_ff) * SQ1_W'(ay_ff);
         numx_ff <= NUM_W'(ax_ff) * NUM_W'(scale_ff);
         numy_ff <= NUM_W'(ay_ff) * NUM_W'(scale_ff);
      end
      if (cmd.sum) begin
         q_ff    <= SQ_W'(sqx_ff) + SQ_W'(sqy_ff);
         tgtx_ff <= TGT_W'(numx_ff) * TGT_W'(numx_ff);
         tgty_ff <= TGT_W'(numy_ff) * TGT_W'(numy_ff);
      end
      if (cmd.tsq) begin
         tsqx_ff <= TSQ_W'(tx) * TSQ_W'(tx);
         tsqy_ff <= TSQ_W'(ty) * TSQ_W'(ty);
      end
      if (cmd.prod) begin
         prodx_ff <= PROD_W'(tsqx_ff) * PROD_W'(q_ff);
         prody_ff <= PROD_W'(tsqy_ff) * PROD_W'(q_ff);
      end
      if (cmd.cmp) begin
         if (TGT_W'(prodx_ff) <= tgtx_ff && prodx_ff[PROD_W-1:TGT_W] == '0) begin
            kx_ff <= tx;
         end
         if (TGT_W'(prody_ff) <= tgty_ff && prody_ff[PROD_W-1:TGT_W] == '0) begin
            ky_ff <= ty;
         end
      end
      if (cmd.out_load) begin
         out_lift_ff <= lift_ff;
         if (lift_ff) begin
            out_dx_ff <= '0;
            out_dy_ff <= '0;
            out_sx_ff <= '0;
            out_sy_ff <= '0;
         end else begin
            out_dx_ff <= dx_ff;
            out_dy_ff <= dy_ff;
            out_sx_ff <= dx_ff[DELTA_W-1] ? SPEED_W'(0) - SPEED_W'(kx_out) : SPEED_W'(kx_out);
            out_sy_ff <= dy_ff[DELTA_W-1] ? SPEED_W'(0) - SPEED_W'(ky_out) : SPEED_W'(ky_out);
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign out_lift   = out_lift_ff;
   assign out_dx     = out_dx_ff;
   assign out_dy     = out_dy_ff;
   assign out_sx     = out_sx_ff;
   assign out_sy     = out_sy_ff;

endmodule

// ----- sv/stroke_to_motion_segments.sv -----
// Move: the result is loaded into the output register after the load, square/scale and sum steps
//   and the 8-bit speed search (per bit: square, multiply by Q, compare); no new point is taken meanwhile.
// Lift (stroke end): the result goes from the load straight to the output register, with no search.
// The next input is taken while a finished result still waits in the output register.
// Reset (synchronous, active high): speed_scale = 100, last point = origin, no result pending.
module stroke_to_motion_segments (
   input  logic                               clock,
   input  logic                               reset,
   // configuration: speed_scale
   input  logic                               csr_wen,
   input  logic [stms_pkg::SCALE_W-1:0]       csr_wdata,
   // input points
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [stms_pkg::IN_DATA_W-1:0]     req_tdata,  // x, y
   input  logic                               req_tlast,  // stroke_end
   // motion segments
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [stms_pkg::OUT_DATA_W-1:0]    rsp_tdata,  // delta_x, delta_y, speed_x, speed_y
   output logic                               rsp_tuser   // is_lift
);
   import stms_pkg::*;

   cmd_type    cmd;
   status_type status;

   logic [COORD_BITS-1:0]   in_x, in_y;
   logic                    out_lift;
   logic signed [DELTA_W-1:0] out_dx, out_dy;
   logic signed [SPEED_W-1:0] out_sx, out_sy;

   // unpack the point; upper pad bits of tdata are ignored
   assign in_x = req_tdata[COORD_BITS-1:0];
   assign in_y = req_tdata[2*COORD_BITS-1:COORD_BITS];

   // sequencer: load, square/scale, sum, then an MSB-first search for each speed
   // magnitude k (largest k with k^2 * Q <= (|delta| * scale)^2), both axes at once
   stms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: last point, delta, squares, targets, search registers, output register
   stms_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .in_x       (in_x),
      .in_y       (in_y),
      .in_lift    (req_tlast),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .out_lift   (out_lift),
      .out_dx     (out_dx),
      .out_dy     (out_dy),
      .out_sx     (out_sx),
      .out_sy     (out_sy)
   );

   // pack the result, first field in the low bits, zero fill to whole bytes
   always_comb begin
      rsp_tdata                  = '0;
      rsp_tdata[OUT_RAW_W-1:0]   = {out_sy, out_sx, out_dy, out_dx};
   end

   assign rsp_tuser = out_lift;

endmodule
